// ===== rtl/c2d_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the 3x3 convolution unit.
// No dependencies; used by the interfaces and every module.
package c2d_pkg;

    localparam int KERNEL   = 3;
    localparam int MAX_ROWS = 64;
    localparam int ROW_W    = 6;
    localparam int COL_W    = 10;  // holds a column for widths up to 1024
    localparam int CH_W     = 6;   // holds a channel for up to 64 input channels
    localparam int F_W      = 4;
    localparam int NUM_BIAS = 16;
    localparam int PSUM_W   = 36;  // nine 32-bit products
    localparam int ACC_W    = 40;  // all channels plus bias, never overflows
    localparam int QDEPTH   = 16;
    localparam int QAW      = 4;
    localparam int PEND_W   = 5;

    typedef enum logic [1:0] {
        ACT_WEIGHT = 2'd0,
        ACT_BIAS   = 2'd1,
        ACT_SAMPLE = 2'd2,
        ACT_NONE   = 2'd3   // reserved, ignored by the unit
    } t_action;

    typedef enum logic [1:0] {
        REG_ROWS   = 2'd0,
        REG_COLS   = 2'd1,
        REG_IN_CH  = 2'd2,
        REG_OUT_CH = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [1:0]          action;
        logic [3:0]          out_channel;
        logic [3:0]          in_channel;
        logic [1:0]          tap_row;
        logic [1:0]          kernel_col;
        logic signed [15:0]  value;
        logic signed [31:0]  bias_value;
    } t_in_beat;

    typedef struct packed {
        logic [3:0]          filter;
        logic [5:0]          out_row;
        logic [5:0]          out_col;
        logic signed [31:0]  result;
        logic                last;
        logic                frame_done;
    } t_res_beat;

    typedef struct packed {
        logic [1:0] index;
        logic [6:0] value;
    } t_cfg_beat;

    // one tap-step of work traveling down the cell chain
    typedef struct packed {
        logic             valid;
        logic [F_W-1:0]   f;
        logic [ROW_W-1:0] i;
        logic [1:0]       islot;
        logic [COL_W-1:0] j;
        logic [CH_W-1:0]  c;
        logic             first;
        logic             lastc;
        logic             last;
        logic             fdone;
    } t_tok;

    typedef struct packed {
        logic [6:0] h;
        logic [6:0] w;
    } t_dims;

    typedef struct packed {
        logic               en;
        logic [3:0]         f;
        logic [3:0]         c;
        logic [3:0]         tap;
        logic signed [15:0] data;
    } t_wwr;

    typedef struct packed {
        logic               en;
        logic [1:0]         slot;
        logic [COL_W-1:0]   col;
        logic [CH_W-1:0]    ch;
        logic signed [15:0] data;
    } t_lwr;

    // line slots rotate modulo three
    function automatic logic [1:0] slot_dec(input logic [1:0] s);
        return (s == 2'd0) ? 2'd2 : s - 2'd1;
    endfunction

    function automatic logic [1:0] slot_inc(input logic [1:0] s);
        return (s == 2'd2) ? 2'd0 : s + 2'd1;
    endfunction

endpackage

// ===== rtl/c2d_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces: sample input, result output, register writes.
// Depends on c2d_pkg for the beat types.
interface c2d_in_if;
    logic             valid;
    logic             ready;
    c2d_pkg::t_in_beat data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface c2d_res_if;
    logic               valid;
    logic               ready;
    c2d_pkg::t_res_beat data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface c2d_cfg_if;
    logic               valid;
    logic               ready;
    c2d_pkg::t_cfg_beat data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/c2d_cell.sv =====
`timescale 1ns / 1ps
// One kernel tap of the MAC chain: weight bank, line copy, multiplier, adder.
// Depends on c2d_pkg.
module c2d_cell #(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_IN_CH  = 16,
    parameter int MAX_OUT_CH = 16,
    parameter int KI         = 0,
    parameter int KJ         = 0
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  c2d_pkg::t_dims                      i_dims,
    input  c2d_pkg::t_wwr                       i_wwr,
    input  c2d_pkg::t_lwr                       i_lwr,
    input  c2d_pkg::t_tok                       i_tok,
    input  logic signed [c2d_pkg::PSUM_W-1:0]   i_psum,
    output c2d_pkg::t_tok                       o_tok,
    output logic signed [c2d_pkg::PSUM_W-1:0]   o_psum
);
    localparam int TAP    = KI * c2d_pkg::KERNEL + KJ;
    localparam int LROW   = MAX_WIDTH * MAX_IN_CH;
    localparam int LDEPTH = c2d_pkg::KERNEL * LROW;
    localparam int LAW    = $clog2(LDEPTH);
    localparam int WDEPTH = MAX_OUT_CH * MAX_IN_CH;
    localparam int WAW    = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;

    logic signed [15:0] r_wmem [WDEPTH];
    logic signed [15:0] r_lmem [LDEPTH];

    c2d_pkg::t_tok                    r_tok;
    logic                             r_en;
    logic signed [15:0]               r_w;
    logic signed [15:0]               r_x;
    logic signed [31:0]               r_prod;
    logic signed [c2d_pkg::PSUM_W-1:0] r_psum;

    logic                             w_row_ok;
    logic                             w_col_ok;
    logic [1:0]                       w_slot;
    logic [c2d_pkg::COL_W-1:0]        w_jj;
    logic [LAW-1:0]                   n_laddr;
    logic [WAW-1:0]                   n_waddr;
    logic [LAW-1:0]                   w_lwaddr;
    logic [WAW-1:0]                   w_wwaddr;

    // tap position relative to the output pixel, with zero padding
    always_comb begin
        w_row_ok = 1'b1;
        w_slot   = i_tok.islot;
        if (KI == 0) begin
            w_row_ok = (i_tok.i != '0);
            w_slot   = c2d_pkg::slot_dec(i_tok.islot);
        end else if (KI == 2) begin
            w_row_ok = (int'(i_tok.i) + 1 < int'(i_dims.h));
            w_slot   = c2d_pkg::slot_inc(i_tok.islot);
        end
        w_col_ok = 1'b1;
        w_jj     = i_tok.j;
        if (KJ == 0) begin
            w_col_ok = (i_tok.j != '0);
            w_jj     = i_tok.j - 1'b1;
        end else if (KJ == 2) begin
            w_col_ok = (int'(i_tok.j) + 1 < int'(i_dims.w));
            w_jj     = i_tok.j + 1'b1;
        end
        n_laddr = '0;
        if (w_row_ok && w_col_ok) begin
            n_laddr = LAW'(int'(w_slot) * LROW + int'(w_jj) * MAX_IN_CH + int'(i_tok.c));
        end
        n_waddr  = WAW'(int'(i_tok.f) * MAX_IN_CH + int'(i_tok.c));
        w_lwaddr = LAW'(int'(i_lwr.slot) * LROW + int'(i_lwr.col) * MAX_IN_CH
                        + int'(i_lwr.ch));
        w_wwaddr = WAW'(int'(i_wwr.f) * MAX_IN_CH + int'(i_wwr.c));
    end

    // coefficient and line memories
    always_ff @(posedge i_clk) begin
        if (i_wwr.en && i_wwr.tap == 4'(TAP)) begin
            r_wmem[w_wwaddr] <= i_wwr.data;
        end
        if (i_lwr.en) begin
            r_lmem[w_lwaddr] <= i_lwr.data;
        end
        r_w <= r_wmem[n_waddr];
        r_x <= r_lmem[n_laddr];
    end

    // token hop, multiply, then add into the passing partial sum
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
            r_en        <= 1'b0;
        end else begin
            r_tok <= i_tok;
            r_en  <= i_tok.valid && w_row_ok && w_col_ok;
        end
        r_prod <= r_en ? r_w * r_x : 32'sd0;
        r_psum <= i_psum + {{(c2d_pkg::PSUM_W - 32){r_prod[31]}}, r_prod};
    end

    assign o_tok  = r_tok;
    assign o_psum = r_psum;

endmodule

// ===== rtl/c2d_acc.sv =====
`timescale 1ns / 1ps
// Channel accumulator, bias store, saturation and result queue at chain end.
// Depends on c2d_pkg and c2d_res_if.
module c2d_acc (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_bias_we,
    input  logic [3:0]                        i_bias_idx,
    input  logic signed [31:0]                i_bias_val,
    input  c2d_pkg::t_tok                     i_tok,
    input  logic signed [c2d_pkg::PSUM_W-1:0] i_psum,
    output logic                              o_push,
    c2d_res_if.source                         o_res
);
    localparam int AW = c2d_pkg::ACC_W;

    logic signed [31:0]      r_bias [c2d_pkg::NUM_BIAS];
    c2d_pkg::t_tok           r_d1;
    c2d_pkg::t_tok           r_d2;
    logic signed [AW-1:0]    r_acc;
    c2d_pkg::t_res_beat      r_q [c2d_pkg::QDEPTH];
    logic [c2d_pkg::QAW-1:0] r_wp;
    logic [c2d_pkg::QAW-1:0] r_rp;
    logic [c2d_pkg::QAW:0]   r_cnt;

    logic signed [AW-1:0]    w_base;
    logic signed [AW-1:0]    w_sum;
    logic signed [31:0]      w_sat;
    logic                    w_push;
    logic                    w_pop;
    logic signed [31:0]      w_bias;

    // sum over channels; bias enters with the first channel
    always_comb begin
        w_bias = r_bias[r_d2.f];
        w_base = r_d2.first ? {{(AW - 32){w_bias[31]}}, w_bias} : r_acc;
        w_sum  = w_base + {{(AW - c2d_pkg::PSUM_W){i_psum[c2d_pkg::PSUM_W-1]}}, i_psum};
        if (w_sum[AW-1:31] == '0 || w_sum[AW-1:31] == '1) begin
            w_sat = w_sum[31:0];
        end else begin
            w_sat = w_sum[AW-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        w_push = r_d2.valid && r_d2.lastc;
        w_pop  = o_res.valid && o_res.ready;
    end

    // bias store and queue control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < c2d_pkg::NUM_BIAS; k++) begin
                r_bias[k] <= 32'sd0;
            end
            r_d1.valid <= 1'b0;
            r_d2.valid <= 1'b0;
            r_wp       <= '0;
            r_rp       <= '0;
            r_cnt      <= '0;
        end else begin
            if (i_bias_we) begin
                r_bias[i_bias_idx] <= i_bias_val;
            end
            r_d1 <= i_tok;
            r_d2 <= r_d1;
            if (w_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (c2d_pkg::QAW + 1)'(w_push) - (c2d_pkg::QAW + 1)'(w_pop);
        end
    end

    // accumulator and queue payload
    always_ff @(posedge i_clk) begin
        if (r_d2.valid) begin
            r_acc <= w_sum;
        end
        if (w_push) begin
            r_q[r_wp] <= '{filter:     r_d2.f,
                           out_row:    r_d2.i,
                           out_col:    r_d2.j[5:0],
                           result:     w_sat,
                           last:       r_d2.last,
                           frame_done: r_d2.fdone};
        end
    end

    assign o_push     = w_push;
    assign o_res.valid = (r_cnt != '0);
    assign o_res.data  = r_q[r_rp];

endmodule

// ===== rtl/conv2d_3x3_same_padding_unit.sv =====
`timescale 1ns / 1ps
// Top level of the 3x3 same-padding convolution unit: sequencer and cell chain.
// Depends on c2d_pkg, c2d_if, c2d_cell and c2d_acc.
//
// Usage. Register writes arrive on i_cfg (always ready) and restart the frame;
// the user must make them only while the unit is idle, which the block itself
// does not enforce. Beats on i_in either load a weight, load a bias, or carry
// one sample; channels of a pixel follow each other and pixels come in raster
// order. When a pixel's last channel arrives the unit emits, on o_res, every
// output position that became complete: filters in ascending order, positions
// in raster order within a filter. Each result is built by a chain of nine
// tap cells, one per kernel tap; one channel of one result enters the chain
// per cycle while the result queue has room. No beat on i_in is taken until
// every result of the preceding pixel has been issued and has reached the queue.
// Reset clears counters, biases and the result queue and loads the register
// defaults (4 rows, 4 columns, 1 input channel, 8 filters). Weights and line
// data are undefined until written. A 16-entry result queue decouples the
// receiver: a stall on o_res stops issue only once the queue is spoken for.
module conv2d_3x3_same_padding_unit #(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_IN_CH  = 16,
    parameter int MAX_OUT_CH = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    c2d_in_if.sink     i_in,
    c2d_cfg_if.sink    i_cfg,
    c2d_res_if.source  o_res
);
    localparam int NCELL = c2d_pkg::KERNEL * c2d_pkg::KERNEL;
    localparam int CW    = c2d_pkg::COL_W;
    localparam int HW    = c2d_pkg::CH_W;
    localparam int PW    = c2d_pkg::PEND_W;

    typedef enum logic {S_IDLE, S_RUN} t_state;

    t_state                    r_state;
    logic [6:0]                r_rows;
    logic [6:0]                r_cols;
    logic [4:0]                r_inch;
    logic [4:0]                r_outch;
    logic [c2d_pkg::ROW_W-1:0] r_row;
    logic [CW-1:0]             r_col;
    logic [HW-1:0]             r_ch;
    logic [1:0]                r_slot;
    logic [c2d_pkg::ROW_W-1:0] r_i0;
    logic [c2d_pkg::ROW_W-1:0] r_i1;
    logic [1:0]                r_is0;
    logic [1:0]                r_is1;
    logic [CW-1:0]             r_j0;
    logic [CW-1:0]             r_j1;
    logic                      r_ni2;
    logic                      r_nj2;
    logic                      r_fend;
    logic [c2d_pkg::F_W-1:0]   r_f;
    logic                      r_a;
    logic                      r_b;
    logic [HW-1:0]             r_c;
    c2d_pkg::t_tok             r_tok;
    logic [PW-1:0]             r_pend;
    logic [PW-1:0]             r_flight;

    logic                      w_accept;
    logic                      w_sample;
    logic                      w_cfg_we;
    logic [6:0]                w_h;
    logic [6:0]                w_w;
    logic [4:0]                w_nc;
    logic [4:0]                w_nf;
    c2d_pkg::t_dims            w_dims;
    logic                      w_wrap;
    logic [c2d_pkg::ROW_W-1:0] w_er;
    logic [CW-1:0]             w_ec;
    logic [HW-1:0]             w_ech;
    logic [1:0]                w_eslot;
    logic                      w_chan_last;
    logic                      w_has_up;
    logic                      w_last_row;
    logic                      w_has_left;
    logic                      w_last_col;
    logic                      w_issue;
    logic                      w_lastc;
    logic                      w_lasta;
    logic                      w_lastb;
    logic                      w_lastf;
    logic                      w_issue_last;
    logic                      w_pop;
    logic                      w_push;
    c2d_pkg::t_wwr             w_wwr;
    c2d_pkg::t_lwr             w_lwr;
    c2d_pkg::t_tok             w_tok  [NCELL + 1];
    logic signed [c2d_pkg::PSUM_W-1:0] w_psum [NCELL + 1];

    // register values in force, with zero read as one and limits applied
    always_comb begin
        w_h  = (r_rows == '0) ? 7'd1 :
               (int'(r_rows) > c2d_pkg::MAX_ROWS) ? 7'(c2d_pkg::MAX_ROWS) : r_rows;
        w_w  = (r_cols == '0) ? 7'd1 :
               (int'(r_cols) > MAX_WIDTH) ? 7'(MAX_WIDTH) : r_cols;
        w_nc = (r_inch == '0) ? 5'd1 :
               (int'(r_inch) > MAX_IN_CH) ? 5'(MAX_IN_CH) : r_inch;
        w_nf = (r_outch == '0) ? 5'd1 :
               (int'(r_outch) > MAX_OUT_CH) ? 5'(MAX_OUT_CH) : r_outch;
        w_dims = '{h: w_h, w: w_w};
    end

    // sample position, wrapped back to the frame start when out of range
    always_comb begin
        w_wrap  = (int'(r_row) >= int'(w_h)) || (int'(r_col) >= int'(w_w))
               || (int'(r_ch) >= int'(w_nc));
        w_er    = w_wrap ? '0 : r_row;
        w_ec    = w_wrap ? '0 : r_col;
        w_ech   = w_wrap ? '0 : r_ch;
        w_eslot = w_wrap ? 2'd0 : r_slot;
        w_chan_last = (int'(w_ech) + 1 >= int'(w_nc));
        w_has_up    = (w_er != '0);
        w_last_row  = (int'(w_er) + 1 == int'(w_h));
        w_has_left  = (w_ec != '0);
        w_last_col  = (int'(w_ec) + 1 == int'(w_w));
    end

    // input handshake and store writes
    always_comb begin
        w_accept = i_in.valid && i_in.ready;
        w_sample = w_accept && (i_in.data.action == c2d_pkg::ACT_SAMPLE);
        w_cfg_we = i_cfg.valid && i_cfg.ready;
        w_wwr.en   = w_accept && (i_in.data.action == c2d_pkg::ACT_WEIGHT)
                  && (int'(i_in.data.out_channel) < MAX_OUT_CH)
                  && (int'(i_in.data.in_channel) < MAX_IN_CH)
                  && (int'(i_in.data.tap_row) < c2d_pkg::KERNEL)
                  && (int'(i_in.data.kernel_col) < c2d_pkg::KERNEL);
        w_wwr.f    = i_in.data.out_channel;
        w_wwr.c    = i_in.data.in_channel;
        w_wwr.tap  = 4'(int'(i_in.data.tap_row) * c2d_pkg::KERNEL
                        + int'(i_in.data.kernel_col));
        w_wwr.data = i_in.data.value;
        w_lwr.en   = w_sample;
        w_lwr.slot = w_eslot;
        w_lwr.col  = w_ec;
        w_lwr.ch   = w_ech;
        w_lwr.data = i_in.data.value;
    end

    // issue: one channel of one result per cycle while the queue has room
    always_comb begin
        w_issue      = (r_state == S_RUN) && (int'(r_pend) < c2d_pkg::QDEPTH);
        w_lastc      = (int'(r_c) + 1 == int'(w_nc));
        w_lastb      = (r_b == r_nj2);
        w_lasta      = (r_a == r_ni2);
        w_lastf      = (int'(r_f) + 1 == int'(w_nf));
        w_issue_last = w_issue && w_lastc;
        w_pop        = o_res.valid && o_res.ready;
    end

    assign i_in.ready  = (r_state == S_IDLE) && (r_flight == '0);
    assign i_cfg.ready = 1'b1;

    // sequencer: counters, position lists, token issue, credits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rows      <= 7'd4;
            r_cols      <= 7'd4;
            r_inch      <= 5'd1;
            r_outch     <= 5'd8;
            r_row       <= '0;
            r_col       <= '0;
            r_ch        <= '0;
            r_slot      <= 2'd0;
            r_tok.valid <= 1'b0;
            r_pend      <= '0;
            r_flight    <= '0;
        end else begin
            r_pend      <= r_pend + PW'(w_issue_last) - PW'(w_pop);
            r_flight    <= r_flight + PW'(w_issue_last) - PW'(w_push);
            r_tok.valid <= w_issue;
            if (w_cfg_we) begin
                unique case (i_cfg.data.index)
                    c2d_pkg::REG_ROWS:   r_rows  <= i_cfg.data.value;
                    c2d_pkg::REG_COLS:   r_cols  <= i_cfg.data.value;
                    c2d_pkg::REG_IN_CH:  r_inch  <= i_cfg.data.value[4:0];
                    c2d_pkg::REG_OUT_CH: r_outch <= i_cfg.data.value[4:0];
                endcase
                r_row  <= '0;
                r_col  <= '0;
                r_ch   <= '0;
                r_slot <= 2'd0;
            end else if (w_sample) begin
                if (!w_chan_last) begin
                    r_row  <= w_er;
                    r_col  <= w_ec;
                    r_slot <= w_eslot;
                    r_ch   <= w_ech + 1'b1;
                end else begin
                    r_ch <= '0;
                    // rows and columns whose neighborhoods just closed
                    if (w_has_up) begin
                        r_i0  <= w_er - 1'b1;
                        r_is0 <= c2d_pkg::slot_dec(w_eslot);
                    end else begin
                        r_i0  <= w_er;
                        r_is0 <= w_eslot;
                    end
                    r_i1  <= w_er;
                    r_is1 <= w_eslot;
                    r_ni2 <= w_has_up && w_last_row;
                    r_j0  <= w_has_left ? w_ec - 1'b1 : w_ec;
                    r_j1  <= w_ec;
                    r_nj2 <= w_has_left && w_last_col;
                    r_fend <= w_last_row && w_last_col;
                    r_f   <= '0;
                    r_a   <= 1'b0;
                    r_b   <= 1'b0;
                    r_c   <= '0;
                    if ((w_has_up || w_last_row) && (w_has_left || w_last_col)) begin
                        r_state <= S_RUN;
                    end
                    // step to the next pixel
                    if (!w_last_col) begin
                        r_row  <= w_er;
                        r_slot <= w_eslot;
                        r_col  <= w_ec + 1'b1;
                    end else begin
                        r_col <= '0;
                        if (!w_last_row) begin
                            r_row  <= w_er + 1'b1;
                            r_slot <= c2d_pkg::slot_inc(w_eslot);
                        end else begin
                            r_row  <= '0;
                            r_slot <= 2'd0;
                        end
                    end
                end
            end
            if (w_issue) begin
                r_tok.f     <= r_f;
                r_tok.i     <= r_a ? r_i1 : r_i0;
                r_tok.islot <= r_a ? r_is1 : r_is0;
                r_tok.j     <= r_b ? r_j1 : r_j0;
                r_tok.c     <= r_c;
                r_tok.first <= (r_c == '0);
                r_tok.lastc <= w_lastc;
                r_tok.last  <= w_lastc && w_lastb && w_lasta && w_lastf;
                r_tok.fdone <= w_lastc && w_lastb && w_lasta && w_lastf && r_fend;
                if (!w_lastc) begin
                    r_c <= r_c + 1'b1;
                end else begin
                    r_c <= '0;
                    if (!w_lastb) begin
                        r_b <= 1'b1;
                    end else begin
                        r_b <= 1'b0;
                        if (!w_lasta) begin
                            r_a <= 1'b1;
                        end else begin
                            r_a <= 1'b0;
                            if (!w_lastf) begin
                                r_f <= r_f + 1'b1;
                            end else begin
                                r_state <= S_IDLE;
                            end
                        end
                    end
                end
            end
        end
    end

    // chain of nine tap cells, partial sum handed along every cycle
    assign w_tok[0]  = r_tok;
    assign w_psum[0] = '0;

    for (genvar k = 0; k < NCELL; k++) begin : g_cell
        c2d_cell #(
            .MAX_WIDTH  (MAX_WIDTH),
            .MAX_IN_CH  (MAX_IN_CH),
            .MAX_OUT_CH (MAX_OUT_CH),
            .KI         (k / c2d_pkg::KERNEL),
            .KJ         (k % c2d_pkg::KERNEL)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_dims  (w_dims),
            .i_wwr   (w_wwr),
            .i_lwr   (w_lwr),
            .i_tok   (w_tok[k]),
            .i_psum  (w_psum[k]),
            .o_tok   (w_tok[k + 1]),
            .o_psum  (w_psum[k + 1])
        );
    end

    c2d_acc u_acc (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_bias_we  (w_accept && (i_in.data.action == c2d_pkg::ACT_BIAS)
                     && (int'(i_in.data.out_channel) < MAX_OUT_CH)),
        .i_bias_idx (i_in.data.out_channel),
        .i_bias_val (i_in.data.bias_value),
        .i_tok      (w_tok[NCELL]),
        .i_psum     (w_psum[NCELL]),
        .o_push     (w_push),
        .o_res      (o_res)
    );

    // results in the chain are a subset of those holding queue credit
    a_flight_le_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_flight <= r_pend)
        else $error("results in flight exceed reserved queue slots");

    a_credit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_pend) <= c2d_pkg::QDEPTH)
        else $error("result queue over-committed");

    a_out_has_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (r_pend != '0))
        else $error("result beat offered without a reserved slot");

    a_no_sample_mid_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_issue |=> !w_sample)
        else $error("sample accepted while results were being issued");

endmodule
